### design/itl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_pkg: shared types and constants for the ipv4 trie lookup
// Field widths, payload structs, command and outcome codes, defaults.
// ----------------------------------------------------------------------------
package itl_pkg;

   // default sizing handed to the top level parameters
   localparam int unsigned MAX_NODES_DEFAULT    = 262144;
   localparam int unsigned ADDRESS_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int unsigned CMD_W        = 1;
   localparam int unsigned NODE_INDEX_W = 18;
   localparam int unsigned PTR_W        = 24;
   localparam int unsigned IP_W         = 32;
   localparam int unsigned COUNT_W      = 19;
   localparam int unsigned COUNTRY_W    = 8;
   localparam int unsigned NODE_W       = 2 * PTR_W;

   // pointers at or above this value are leaves
   localparam logic [PTR_W-1:0] LEAF_BASE = 24'hFFFF00;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

   // lookup outcome codes
   typedef enum logic [1:0] {
      OUTCOME_FOUND     = 2'd0,
      OUTCOME_ZERO_LEAF = 2'd1,
      OUTCOME_RANGE     = 2'd2,
      OUTCOME_NO_LEAF   = 2'd3
   } outcome_type;

   // input item
   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [NODE_INDEX_W-1:0] node_index;
      logic [PTR_W-1:0]        left_pointer;
      logic [PTR_W-1:0]        right_pointer;
      logic [IP_W-1:0]         ip_address;
   } req_type;

   // result item
   typedef struct packed {
      logic [COUNTRY_W-1:0] country_index;
      outcome_type          outcome;
   } rsp_type;

   // classified item held in the queue
   typedef struct packed {
      logic                    is_lookup;
      logic                    write_ok;
      logic [NODE_INDEX_W-1:0] node_index;
      logic [PTR_W-1:0]        left_pointer;
      logic [PTR_W-1:0]        right_pointer;
      logic [IP_W-1:0]         ip_address;
   } work_type;

endpackage

### design/itl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_front: request classification and queue
// Accepts request transfers, tags loads and lookups, and buffers them in a
// short fifo for the trie walker.
// ----------------------------------------------------------------------------
module itl_front #(
   parameter int unsigned MAX_NODES = itl_pkg::MAX_NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itl_pkg::req_type  req_payload,
   output logic              work_valid,
   input  logic              work_ready,
   output itl_pkg::work_type work_payload
);

   localparam logic [itl_pkg::PTR_W-1:0] NODE_LIMIT = itl_pkg::PTR_W'(MAX_NODES);

   itl_pkg::work_type                entry;
   itl_pkg::work_type                slot_ff [itl_pkg::QUEUE_DEPTH];
   logic [itl_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [itl_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [itl_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             push, pop;
   logic [itl_pkg::PTR_W-1:0]        node_ext;

   // classify the incoming item
   always_comb begin
      node_ext           = itl_pkg::PTR_W'(req_payload.node_index);
      entry.is_lookup     = (req_payload.cmd == itl_pkg::CMD_LOOKUP);
      entry.write_ok      = (node_ext < NODE_LIMIT);
      entry.node_index    = req_payload.node_index;
      entry.left_pointer  = req_payload.left_pointer;
      entry.right_pointer = req_payload.right_pointer;
      entry.ip_address    = req_payload.ip_address;
   end

   // handshakes
   assign req_ready    = (count_ff != itl_pkg::QCNT_W'(itl_pkg::QUEUE_DEPTH));
   assign work_valid   = (count_ff != '0);
   assign work_payload = slot_ff[rd_ptr_ff];
   assign push         = req_valid && req_ready;
   assign pop          = work_valid && work_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == itl_pkg::QPTR_W'(itl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == itl_pkg::QPTR_W'(itl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### design/itl_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_walker: trie memory and walk sequencer
// Writes nodes for loads and walks the trie one node read per cycle for
// lookups, holding the result in an output register.
// ----------------------------------------------------------------------------
module itl_walker #(
   parameter int unsigned MAX_NODES    = itl_pkg::MAX_NODES_DEFAULT,
   parameter int unsigned ADDRESS_BITS = itl_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         work_valid,
   output logic                         work_ready,
   input  itl_pkg::work_type            work_payload,
   input  logic                         csr_write_enable,
   input  logic [itl_pkg::COUNT_W-1:0]  csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output itl_pkg::rsp_type             rsp_payload
);

   localparam int unsigned NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int unsigned CNT_W   = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
   localparam logic [itl_pkg::PTR_W-1:0] NODE_LIMIT = itl_pkg::PTR_W'(MAX_NODES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [itl_pkg::IP_W-1:0]       ip_ff, ip_in;
   logic [CNT_W-1:0]               steps_ff, steps_in;
   itl_pkg::rsp_type               res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   itl_pkg::rsp_type               rsp_ff, rsp_in;
   logic [itl_pkg::PTR_W-1:0]      limit_ff, limit_in;

   logic [itl_pkg::NODE_W-1:0]     mem [MAX_NODES];
   logic [itl_pkg::NODE_W-1:0]     rdata_ff;
   logic                           rd_en;
   logic [NODE_AW-1:0]             rd_addr;
   logic                           wr_en;
   logic [NODE_AW-1:0]             wr_addr;
   logic [itl_pkg::PTR_W-1:0]      wr_node_ext;
   logic [itl_pkg::PTR_W-1:0]      csr_ext;

   logic [itl_pkg::PTR_W-1:0]      nxt;
   logic                           nxt_leaf;

   // pointer chosen by the current address bit
   assign nxt      = ip_ff[itl_pkg::IP_W-1] ? rdata_ff[itl_pkg::NODE_W-1:itl_pkg::PTR_W]
                                            : rdata_ff[itl_pkg::PTR_W-1:0];
   assign nxt_leaf = (nxt >= itl_pkg::LEAF_BASE);

   assign wr_node_ext = itl_pkg::PTR_W'(work_payload.node_index);
   assign wr_addr     = wr_node_ext[NODE_AW-1:0];

   // node count clamped to the memory depth
   assign csr_ext  = itl_pkg::PTR_W'(csr_write_data);
   assign limit_in = csr_write_enable ? ((csr_ext > NODE_LIMIT) ? NODE_LIMIT : csr_ext)
                                      : limit_ff;

   assign work_ready  = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // walk sequencer next state
   always_comb begin
      state_in     = state_ff;
      ip_in        = ip_ff;
      steps_in     = steps_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (work_valid) begin
               if (!work_payload.is_lookup) begin
                  wr_en = work_payload.write_ok;
               end else begin
                  ip_in    = work_payload.ip_address << (itl_pkg::IP_W - ADDRESS_BITS);
                  steps_in = CNT_W'(ADDRESS_BITS - 1);
                  if (limit_ff == '0) begin
                     res_in.country_index = '0;
                     res_in.outcome       = itl_pkg::OUTCOME_RANGE;
                     state_in             = S_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            if (nxt_leaf) begin
               res_in.country_index = nxt[itl_pkg::COUNTRY_W-1:0];
               res_in.outcome       = (nxt[itl_pkg::COUNTRY_W-1:0] == '0) ?
                                      itl_pkg::OUTCOME_ZERO_LEAF : itl_pkg::OUTCOME_FOUND;
               state_in             = S_DONE;
            end else if (steps_ff == '0) begin
               res_in.country_index = '0;
               res_in.outcome       = itl_pkg::OUTCOME_NO_LEAF;
               state_in             = S_DONE;
            end else if (nxt >= limit_ff) begin
               res_in.country_index = '0;
               res_in.outcome       = itl_pkg::OUTCOME_RANGE;
               state_in             = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = nxt[NODE_AW-1:0];
               ip_in    = ip_ff << 1;
               steps_in = steps_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
      ip_ff    <= ip_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // trie node memory, right pointer in the upper half
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {work_payload.right_pointer, work_payload.left_pointer};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

endmodule

### design/ipv4_country_trie_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_country_trie_lookup: binary trie ipv4 prefix to country index lookup
// Load requests write one trie node; lookup requests walk the trie.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries load and lookup items. A load writes
//   one node, left and right pointers, and gives no response. A lookup
//   gives one rsp transfer with the country index and an outcome code.
//   csr_write_enable/csr_write_data set the loaded node count; write it only
//   while the block is idle. Zero means no database.
// Throughput:
//   a two-entry queue takes request transfers while the walker is busy.
//   A load writes its node from the idle state. A lookup reads one node
//   per cycle from the node memory for up to ADDRESS_BITS nodes, and
//   ends early when a leaf or an out-of-range node is met; the result
//   then moves to the output register.
// Reset:
//   clears the queue, the walker state, the response valid and the node
//   count. The node memory is not cleared; nodes must be loaded first.
// Stalls:
//   a response held by a low rsp_ready stays in its output register; the
//   walker finishes the next lookup and waits until that register frees.
// ----------------------------------------------------------------------------
module ipv4_country_trie_lookup #(
   parameter int unsigned MAX_NODES    = itl_pkg::MAX_NODES_DEFAULT,
   parameter int unsigned ADDRESS_BITS = itl_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  itl_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output itl_pkg::rsp_type             rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [itl_pkg::COUNT_W-1:0]  csr_write_data
);

   logic              work_valid;
   logic              work_ready;
   itl_pkg::work_type work_payload;

   // front: classification and queue
   itl_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .work_valid   (work_valid),
      .work_ready   (work_ready),
      .work_payload (work_payload)
   );

   // back: node memory and walker
   itl_walker #(
      .MAX_NODES    (MAX_NODES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_walker (
      .clock            (clock),
      .reset            (reset),
      .work_valid       (work_valid),
      .work_ready       (work_ready),
      .work_payload     (work_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule

### design/itl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itl_checker: port-level checks for the trie lookup
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module itl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input itl_pkg::rsp_type rsp_payload
);

   // no response straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // empty queue takes a request transfer after reset
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // unknown outcomes carry a zero country index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.outcome != itl_pkg::OUTCOME_FOUND)
      |-> (rsp_payload.country_index == '0))
      else $error("unknown outcome with non-zero country index");

   // found outcome never carries index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.outcome == itl_pkg::OUTCOME_FOUND)
      |-> (rsp_payload.country_index != '0))
      else $error("found outcome with zero country index");

endmodule

bind ipv4_country_trie_lookup itl_checker u_checker (.*);

### sim/trie_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_lookup_checker: predicts and checks ipv4 trie lookup results
// Watches the request, response and csr ports, keeps its own copy of the
// trie nodes and node count, walks each accepted lookup and compares every
// response transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module trie_lookup_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  itl_pkg::req_type             req_payload,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  itl_pkg::rsp_type             rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [itl_pkg::COUNT_W-1:0]  csr_write_data,
   input  logic                         run_done,
   output int unsigned                  pending,
   output int unsigned                  failures,
   output int unsigned                  results_checked
);

   localparam int unsigned NODE_LIMIT = itl_pkg::MAX_NODES_DEFAULT;
   localparam int unsigned WALK_BITS  = itl_pkg::ADDRESS_BITS_DEFAULT;

   // own copy of the trie and the node count
   logic [itl_pkg::PTR_W-1:0]   left_mem  [NODE_LIMIT];
   logic [itl_pkg::PTR_W-1:0]   right_mem [NODE_LIMIT];
   logic [itl_pkg::COUNT_W-1:0] node_count;

   // results predicted for accepted lookups, oldest first
   itl_pkg::rsp_type predicted_lookups [$];
   itl_pkg::rsp_type oldest;
   bit               leftovers_reported;

   // walk the trie from node 0, top address bit first
   function automatic itl_pkg::rsp_type walk_trie(input logic [itl_pkg::IP_W-1:0] addr);
      itl_pkg::rsp_type          res;
      int unsigned               limit;
      int unsigned               node;
      logic [itl_pkg::PTR_W-1:0] next_ptr;
      limit = (32'(node_count) > NODE_LIMIT) ? NODE_LIMIT : 32'(node_count);
      node  = 0;
      res.country_index = '0;
      res.outcome       = itl_pkg::OUTCOME_NO_LEAF;
      for (int b = WALK_BITS - 1; b >= 0; b--) begin
         if (node >= limit) begin
            res.outcome = itl_pkg::OUTCOME_RANGE;
            return res;
         end
         next_ptr = addr[b] ? right_mem[node] : left_mem[node];
         if (next_ptr >= itl_pkg::LEAF_BASE) begin
            res.country_index = itl_pkg::COUNTRY_W'(next_ptr - itl_pkg::LEAF_BASE);
            res.outcome = (res.country_index == '0) ? itl_pkg::OUTCOME_ZERO_LEAF
                                                    : itl_pkg::OUTCOME_FOUND;
            return res;
         end
         node = 32'(next_ptr);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         node_count <= '0;
         predicted_lookups.delete();
         failures           = 0;
         results_checked    = 0;
         leftovers_reported = 1'b0;
      end else begin
         // register write, only ever done while idle
         if (csr_write_enable)
            node_count <= csr_write_data;

         // request transfer: node write or predicted lookup
         if (req_valid && req_ready) begin
            if (req_payload.cmd == itl_pkg::CMD_LOOKUP) begin
               predicted_lookups.push_back(walk_trie(req_payload.ip_address));
            end else if (32'(req_payload.node_index) < NODE_LIMIT) begin
               left_mem[req_payload.node_index]  = req_payload.left_pointer;
               right_mem[req_payload.node_index] = req_payload.right_pointer;
            end
         end

         // response transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (predicted_lookups.size() == 0) begin
               $error("response with no lookup outstanding: country_index %0d, outcome %0d",
                      rsp_payload.country_index, rsp_payload.outcome);
               failures++;
            end else begin
               oldest = predicted_lookups.pop_front();
               results_checked++;
               if (rsp_payload.country_index !== oldest.country_index) begin
                  $error("country_index mismatch: expected %0d, actual %0d",
                         oldest.country_index, rsp_payload.country_index);
                  failures++;
               end
               if (rsp_payload.outcome !== oldest.outcome) begin
                  $error("outcome mismatch: expected %0d, actual %0d",
                         oldest.outcome, rsp_payload.outcome);
                  failures++;
               end
            end
         end

         // end of run: anything still predicted never came back
         if (run_done && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            if (predicted_lookups.size() != 0) begin
               $error("%0d lookup results never arrived", predicted_lookups.size());
               failures += predicted_lookups.size();
            end
         end
      end
      pending = predicted_lookups.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: ipv4 trie lookup testbench top
// Builds small tries under a range of node counts, from no database up to
// beyond the memory size, and fires lookups at them with random gaps on the
// request side and random back-pressure on the response side. Checking is
// done by the trie lookup checker sitting beside the block.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned NODE_LIMIT    = itl_pkg::MAX_NODES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS   = 170;
   localparam int unsigned LEAF_FIRST    = 16776960;
   localparam logic [itl_pkg::PTR_W-1:0]   PTR_MAX   = {itl_pkg::PTR_W{1'b1}};
   localparam logic [itl_pkg::COUNT_W-1:0] COUNT_MAX = {itl_pkg::COUNT_W{1'b1}};

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   itl_pkg::req_type            req_payload;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   itl_pkg::rsp_type            rsp_payload;
   logic                        csr_write_enable;
   logic [itl_pkg::COUNT_W-1:0] csr_write_data;
   logic                        run_done;

   int unsigned pending;
   int unsigned failures;
   int unsigned results_checked;

   // stimulus side view of the trie, used to keep lookups off unwritten nodes
   logic [itl_pkg::PTR_W-1:0] shadow_left  [NODE_LIMIT];
   logic [itl_pkg::PTR_W-1:0] shadow_right [NODE_LIMIT];
   bit                        node_written [NODE_LIMIT];
   int unsigned               active_count;
   int unsigned               phase_nodes [$];
   bit                        burst;

   int unsigned lookups_sent;
   int unsigned loads_sent;
   int unsigned settings_done;
   int unsigned cycle_count;
   int unsigned ready_hold;
   int unsigned ready_pick;

   ipv4_country_trie_lookup u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   trie_lookup_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .run_done         (run_done),
      .pending          (pending),
      .failures         (failures),
      .results_checked  (results_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[ipv4_country_trie_lookup] ERROR");
         $finish;
      end
   end

   // response back-pressure: short stalls mostly, some long ones, some long open stretches
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 55) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 7);
         end else if (ready_pick < 65) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(50, 200);
         end else if (ready_pick < 92) begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(10, 60);
         end
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   // request gap length, mostly back to back
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // pointer for a node: leaf, node of this trie, out of range, or anything
   function automatic logic [itl_pkg::PTR_W-1:0] pick_pointer();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35)
         return itl_pkg::LEAF_BASE + itl_pkg::PTR_W'($urandom_range(0, 255));
      if (r < 75 && phase_nodes.size() != 0)
         return itl_pkg::PTR_W'(phase_nodes[$urandom_range(0, phase_nodes.size() - 1)]);
      if (r < 90)
         return itl_pkg::PTR_W'($urandom_range(active_count, LEAF_FIRST - 1));
      return itl_pkg::PTR_W'($urandom);
   endfunction

   // a lookup may only pass through nodes that have been written
   function automatic bit walk_is_safe(input logic [itl_pkg::IP_W-1:0] addr);
      int unsigned               node;
      logic [itl_pkg::PTR_W-1:0] nxt;
      node = 0;
      for (int b = itl_pkg::IP_W - 1; b >= 0; b--) begin
         if (node >= active_count)
            return 1'b1;
         if (!node_written[node])
            return 1'b0;
         nxt = addr[b] ? shadow_right[node] : shadow_left[node];
         if (nxt >= itl_pkg::LEAF_BASE)
            return 1'b1;
         node = 32'(nxt);
      end
      return 1'b1;
   endfunction

   // one request transfer; valid is left high for a back to back follower
   task automatic send_item(input itl_pkg::req_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (item.cmd == itl_pkg::CMD_LOAD) begin
         shadow_left[item.node_index]  = item.left_pointer;
         shadow_right[item.node_index] = item.right_pointer;
         node_written[item.node_index] = 1'b1;
         loads_sent++;
      end else begin
         lookups_sent++;
      end
   endtask

   task automatic load_node(input int unsigned idx, input logic [itl_pkg::PTR_W-1:0] lp,
                            input logic [itl_pkg::PTR_W-1:0] rp);
      itl_pkg::req_type item;
      item.cmd           = itl_pkg::CMD_LOAD;
      item.node_index    = itl_pkg::NODE_INDEX_W'(idx);
      item.left_pointer  = lp;
      item.right_pointer = rp;
      item.ip_address    = $urandom;
      send_item(item);
   endtask

   task automatic lookup_addr(input logic [itl_pkg::IP_W-1:0] addr);
      itl_pkg::req_type item;
      item.cmd           = itl_pkg::CMD_LOOKUP;
      item.node_index    = itl_pkg::NODE_INDEX_W'($urandom);
      item.left_pointer  = itl_pkg::PTR_W'($urandom);
      item.right_pointer = itl_pkg::PTR_W'($urandom);
      item.ip_address    = addr;
      send_item(item);
   endtask

   // stop sending and let every outstanding lookup come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [itl_pkg::COUNT_W-1:0] value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = (32'(value) > NODE_LIMIT) ? NODE_LIMIT : 32'(value);
      settings_done++;
   endtask

   // one node-count setting: build a small trie, then mixed traffic on it
   task automatic run_phase(input logic [itl_pkg::COUNT_W-1:0] setting,
                            input int unsigned items);
      int unsigned span;
      int unsigned r;
      int unsigned tries;
      logic [itl_pkg::IP_W-1:0] addr;
      bit ok;
      write_node_count(setting);
      phase_nodes.delete();
      span = (active_count == 0) ? 0 :
             $urandom_range(1, (active_count < 24) ? active_count : 24);
      for (int unsigned i = 0; i < span; i++)
         phase_nodes.push_back(i);
      if (active_count > 1024) begin
         phase_nodes.push_back(NODE_LIMIT - 1);
         repeat (4) phase_nodes.push_back($urandom_range(1024, active_count - 1));
      end
      if (active_count == 0)
         repeat (3) phase_nodes.push_back($urandom_range(0, NODE_LIMIT - 1));
      foreach (phase_nodes[i])
         load_node(phase_nodes[i], pick_pointer(), pick_pointer());

      for (int unsigned n = 0; n < items; n++) begin
         if (n % 40 == 0)
            burst = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 2)
            wait_until_drained();
         if (r < 78) begin
            ok = 1'b0;
            tries = 0;
            while (!ok && tries < 16) begin
               addr = $urandom;
               ok = walk_is_safe(addr);
               tries++;
            end
            if (ok)
               lookup_addr(addr);
            else
               load_node(phase_nodes[$urandom_range(0, phase_nodes.size() - 1)],
                         pick_pointer(), pick_pointer());
         end else if (r < 95) begin
            load_node(phase_nodes[$urandom_range(0, phase_nodes.size() - 1)],
                      pick_pointer(), pick_pointer());
         end else begin
            load_node($urandom_range(0, NODE_LIMIT - 1), itl_pkg::PTR_W'($urandom),
                      itl_pkg::PTR_W'($urandom));
         end
      end
   endtask

   initial begin
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      run_done         <= 1'b0;
      reset            <= 1'b1;
      lookups_sent     = 0;
      loads_sent       = 0;
      settings_done    = 0;
      active_count     = 0;
      burst            = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // no database loaded yet
      lookup_addr('0);

      // three node trie: zero leaf, top leaf, self loop, out of range pointer
      write_node_count(itl_pkg::COUNT_W'(3));
      load_node(0, itl_pkg::LEAF_BASE, itl_pkg::PTR_W'(1));
      load_node(1, PTR_MAX, itl_pkg::PTR_W'(2));
      load_node(2, itl_pkg::PTR_W'(2), itl_pkg::LEAF_BASE - itl_pkg::PTR_W'(1));
      load_node(NODE_LIMIT - 1, PTR_MAX, PTR_MAX);
      lookup_addr(32'h0000_0000);
      lookup_addr(32'h7FFF_FFFF);
      lookup_addr(32'h8000_0000);
      lookup_addr(32'hBFFF_FFFF);
      lookup_addr(32'hC000_0000);
      lookup_addr(32'hE000_0000);
      lookup_addr(32'hFFFF_FFFF);
      load_node(0, itl_pkg::LEAF_BASE + 24'h5A, itl_pkg::PTR_W'(1));
      lookup_addr(32'h1234_5678);

      // node two now lies beyond the count
      write_node_count(itl_pkg::COUNT_W'(2));
      lookup_addr(32'hC000_0000);
      lookup_addr(32'hDFFF_FFFF);

      // random traffic over a spread of node counts, extremes included
      run_phase(itl_pkg::COUNT_W'(1), PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'(NODE_LIMIT), PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'($urandom_range(2, 64)), PHASE_ITEMS);
      run_phase(COUNT_MAX, PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'(2), PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'($urandom_range(65, 4096)), PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'(NODE_LIMIT - 1), PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'(0), PHASE_ITEMS);
      run_phase(itl_pkg::COUNT_W'($urandom_range(3, 30)), PHASE_ITEMS);

      // drain, then flag anything left over
      wait_until_drained();
      run_done <= 1'b1;
      @(posedge clock);
      @(posedge clock);
      $display("covered %0d lookups and %0d node writes over %0d node-count settings",
               lookups_sent, loads_sent, settings_done);
      $display("%0d lookup results compared with the predicted walk", results_checked);
      if (failures == 0)
         $display("[ipv4_country_trie_lookup] OK");
      else
         $display("[ipv4_country_trie_lookup] ERROR");
      $finish;
   end

endmodule

### ipv4_country_trie_lookup.f
design/itl_pkg.sv
design/itl_front.sv
design/itl_walker.sv
design/ipv4_country_trie_lookup.sv
design/itl_checker.sv
sim/trie_lookup_checker.sv
sim/tb.sv
